// ----- src/dwvp_pkg.sv -----
`timescale 1ns / 1ps

package dwvp_pkg;

  localparam int SPEED_BITS   = 16;
  localparam int SUM_BITS     = 32;
  localparam int GAIN_BITS    = 32;
  localparam int ERR_BITS     = SPEED_BITS + 1;
  localparam int DIFF_BITS    = SPEED_BITS + 2;
  localparam int PP_BITS      = GAIN_BITS + 1 + ERR_BITS;
  localparam int PI_BITS      = GAIN_BITS + 1 + SUM_BITS;
  localparam int PD_BITS      = GAIN_BITS + 1 + DIFF_BITS;
  localparam int TOT_BITS     = 64;
  localparam int DUTY_BITS    = 16;
  localparam int DUTY_SHIFT   = 22;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [TOT_BITS-1:0]         PROD_LIMIT = TOT_BITS'(1) << 60;
  localparam logic signed [DUTY_BITS-1:0] DUTY_ONE   = 16'sd16384;

  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_GAIN_P  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_GAIN_I  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_GAIN_D  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_GAIN_P = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_GAIN_I = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_GAIN_D = 3'd5;

  localparam logic MODE_STEP   = 1'b0;
  localparam logic MODE_TARGET = 1'b1;

  typedef struct packed {
    logic load_target;
    logic step;
    logic adv2;
    logic adv3;
  } dwvp_ctrl_t;

endpackage

// ----- src/dual_wheel_velocity_pid.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Signals                           Contents
// s_        in         s_tvalid s_tready s_tdata s_tuser  goals or speeds, mode
// m_        out        m_tvalid m_tready m_tdata          left and right duty
// cfg_      in         cfg_we cfg_index cfg_data          six gain registers
//
// One transaction is accepted per cycle while s_tready is high, which back-pressure on m_ can drop;
// a duty transaction leaves after its control transaction passes the error, multiply, sum and clamp stages.
// Each stage holds only while the stage after it is full and held, so bubbles are squeezed out.
// Set-target transactions update state at once and produce no output.
// Reset clears targets, error sums, last errors, gains and all valid flags.

module dual_wheel_velocity_pid import dwvp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // [15:0] left_goal, [31:16] right_goal, [47:32] left_speed, [63:48] right_speed
  input  logic [63:0]             s_tdata,
  // [0] mode
  input  logic                    s_tuser,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // [15:0] left_duty, [31:16] right_duty
  output logic [31:0]             m_tdata,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [GAIN_BITS-1:0]    cfg_data
);

  logic [GAIN_BITS-1:0] left_gain_p;
  logic [GAIN_BITS-1:0] left_gain_i;
  logic [GAIN_BITS-1:0] left_gain_d;
  logic [GAIN_BITS-1:0] right_gain_p;
  logic [GAIN_BITS-1:0] right_gain_i;
  logic [GAIN_BITS-1:0] right_gain_d;

  logic v1;
  logic v2;
  logic v3;
  logic ready1;
  logic ready2;
  logic ready3;
  logic ready4;
  logic accept;

  dwvp_ctrl_t ctrl;

  logic signed [DUTY_BITS-1:0] left_duty;
  logic signed [DUTY_BITS-1:0] right_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_gain_p  <= '0;
      left_gain_i  <= '0;
      left_gain_d  <= '0;
      right_gain_p <= '0;
      right_gain_i <= '0;
      right_gain_d <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_GAIN_P:  left_gain_p  <= cfg_data;
        REG_LEFT_GAIN_I:  left_gain_i  <= cfg_data;
        REG_LEFT_GAIN_D:  left_gain_d  <= cfg_data;
        REG_RIGHT_GAIN_P: right_gain_p <= cfg_data;
        REG_RIGHT_GAIN_I: right_gain_i <= cfg_data;
        REG_RIGHT_GAIN_D: right_gain_d <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ready4   = !m_tvalid || m_tready;
    ready3   = !v3 || ready4;
    ready2   = !v2 || ready3;
    ready1   = !v1 || ready2;
    s_tready = ready1;
    accept   = s_tvalid && s_tready;
    ctrl.load_target = accept && (s_tuser == MODE_TARGET);
    ctrl.step        = accept && (s_tuser == MODE_STEP);
    ctrl.adv2        = v1 && ready2;
    ctrl.adv3        = v2 && ready3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= ctrl.step;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
      if (ready4) begin
        m_tvalid <= v3;
      end
    end
  end

  dwvp_lane u_left (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .gain_p (left_gain_p),
    .gain_i (left_gain_i),
    .gain_d (left_gain_d),
    .goal   ($signed(s_tdata[15:0])),
    .speed  ($signed(s_tdata[47:32])),
    .duty   (left_duty)
  );

  dwvp_lane u_right (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .gain_p (right_gain_p),
    .gain_i (right_gain_i),
    .gain_d (right_gain_d),
    .goal   ($signed(s_tdata[31:16])),
    .speed  ($signed(s_tdata[63:48])),
    .duty   (right_duty)
  );

  always_ff @(posedge clk) begin
    if (ready4 && v3) begin
      m_tdata <= {right_duty, left_duty};
    end
  end

  a_step_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == MODE_STEP)) |=> v1)
    else $error("accepted control transaction did not enter the pipeline");

  a_empty_is_ready: assert property (@(posedge clk) disable iff (rst)
    (!v1 && !v2 && !v3 && !m_tvalid) |-> s_tready)
    else $error("empty pipeline refuses input");

  a_stage3_holds: assert property (@(posedge clk) disable iff (rst)
    (v3 && !ready4) |=> v3)
    else $error("stage three dropped a result under stall");

  a_left_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[15:0]) <= DUTY_ONE && $signed(m_tdata[15:0]) >= -DUTY_ONE))
    else $error("left duty out of range");

  a_right_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:16]) <= DUTY_ONE && $signed(m_tdata[31:16]) >= -DUTY_ONE))
    else $error("right duty out of range");

endmodule

// ----- src/dwvp_lane.sv -----
`timescale 1ns / 1ps

module dwvp_lane import dwvp_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  dwvp_ctrl_t                   ctrl,
  input  logic [GAIN_BITS-1:0]         gain_p,
  input  logic [GAIN_BITS-1:0]         gain_i,
  input  logic [GAIN_BITS-1:0]         gain_d,
  input  logic signed [SPEED_BITS-1:0] goal,
  input  logic signed [SPEED_BITS-1:0] speed,
  output logic signed [DUTY_BITS-1:0]  duty
);

  localparam logic signed [PI_BITS-1:0] PI_MAX = PI_BITS'(PROD_LIMIT);
  localparam logic signed [PI_BITS-1:0] PI_MIN = -PI_MAX;
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  logic signed [SPEED_BITS-1:0] target;
  logic signed [SUM_BITS-1:0]   error_sum;
  logic signed [ERR_BITS-1:0]   last_error;

  logic signed [ERR_BITS-1:0]   err;
  logic signed [SUM_BITS:0]     sum_wide;
  logic signed [SUM_BITS-1:0]   sum_sat;
  logic signed [DIFF_BITS-1:0]  diff;

  logic signed [ERR_BITS-1:0]   err_s1;
  logic signed [SUM_BITS-1:0]   sum_s1;
  logic signed [DIFF_BITS-1:0]  diff_s1;
  logic                         pos_s1;
  logic                         neg_s1;

  logic signed [PP_BITS-1:0]    prod_p_next;
  logic signed [PI_BITS-1:0]    prod_i_next;
  logic signed [PD_BITS-1:0]    prod_d_next;
  logic signed [PP_BITS-1:0]    prod_p;
  logic signed [PI_BITS-1:0]    prod_i;
  logic signed [PD_BITS-1:0]    prod_d;
  logic                         pos_s2;
  logic                         neg_s2;

  logic signed [PI_BITS-1:0]    prod_i_sat;
  logic signed [TOT_BITS-1:0]   total_next;
  logic signed [TOT_BITS-1:0]   total;
  logic                         pos_s3;
  logic                         neg_s3;

  logic signed [TOT_BITS-1:0]   shifted;
  logic signed [TOT_BITS-1:0]   duty_hi;
  logic signed [TOT_BITS-1:0]   duty_lo;
  logic signed [TOT_BITS-1:0]   duty_wide;

  always_comb begin
    err      = ERR_BITS'(target) - ERR_BITS'(speed);
    sum_wide = (SUM_BITS+1)'(error_sum) + (SUM_BITS+1)'(err);
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      sum_sat = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_BITS-1:0];
    end
    diff = DIFF_BITS'(err) - DIFF_BITS'(last_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target     <= '0;
      error_sum  <= '0;
      last_error <= '0;
    end else if (ctrl.load_target) begin
      target    <= goal;
      error_sum <= '0;
    end else if (ctrl.step) begin
      error_sum  <= sum_sat;
      last_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      err_s1  <= err;
      sum_s1  <= sum_sat;
      diff_s1 <= diff;
      pos_s1  <= !target[SPEED_BITS-1] && (target != '0);
      neg_s1  <= target[SPEED_BITS-1];
    end
  end

  assign prod_p_next = $signed({1'b0, gain_p}) * err_s1;
  assign prod_i_next = $signed({1'b0, gain_i}) * sum_s1;
  assign prod_d_next = $signed({1'b0, gain_d}) * diff_s1;

  always_ff @(posedge clk) begin
    if (ctrl.adv2) begin
      prod_p <= prod_p_next;
      prod_i <= prod_i_next;
      prod_d <= prod_d_next;
      pos_s2 <= pos_s1;
      neg_s2 <= neg_s1;
    end
  end

  always_comb begin
    if (prod_i > PI_MAX) begin
      prod_i_sat = PI_MAX;
    end else if (prod_i < PI_MIN) begin
      prod_i_sat = PI_MIN;
    end else begin
      prod_i_sat = prod_i;
    end
    total_next = TOT_BITS'(prod_p) + TOT_BITS'(prod_i_sat) + TOT_BITS'(prod_d);
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv3) begin
      total  <= total_next;
      pos_s3 <= pos_s2;
      neg_s3 <= neg_s2;
    end
  end

  always_comb begin
    shifted = total >>> DUTY_SHIFT;
    duty_hi = neg_s3 ? '0 : TOT_BITS'(DUTY_ONE);
    duty_lo = pos_s3 ? '0 : -TOT_BITS'(DUTY_ONE);
    if (shifted > duty_hi) begin
      duty_wide = duty_hi;
    end else if (shifted < duty_lo) begin
      duty_wide = duty_lo;
    end else begin
      duty_wide = shifted;
    end
    duty = DUTY_BITS'(duty_wide);
  end

endmodule
